// File: hdl/fsbc_pkg.sv
// ----------------------------------------------------------------------------
// fsbc_pkg
// Shared types and constants of the frustum sphere/box cull block.
// ----------------------------------------------------------------------------
package fsbc_pkg;

  // item kinds carried in the input tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SPHERE = 2'd1;
  localparam logic [1:0] OP_BOX    = 2'd2;

  // result kinds carried in the output tuser
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

  localparam int IN_TDATA_W  = 216;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  localparam int COEF_W = 16;
  localparam int POS_W  = 32;
  localparam int RAD_W  = 31;
  localparam int PROD_W = COEF_W + POS_W;   // 48
  localparam int FRAC_SHIFT = 14;           // Q16.16 -> Q*.30 alignment
  localparam int DIST_W = 52;               // |distance| < 2^49, with headroom

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [POS_W-1:0]  d;
  } plane_t;

  // per-plane verdict returned by the distance pipe
  typedef struct packed {
    logic vld;
    logic sph_cull;   // distance < -radius
    logic box_in;     // distance >= 0
  } dist_res_t;

endpackage

// File: hdl/fsbc_plane_mem.sv
// ----------------------------------------------------------------------------
// fsbc_plane_mem
// Plane storage: one write port, one registered read port, per-entry valid.
// ----------------------------------------------------------------------------
module fsbc_plane_mem #(
  parameter int Depth = 6,
  parameter int AddrW = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  fsbc_pkg::plane_t     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output fsbc_pkg::plane_t     rdata_o
);

  fsbc_pkg::plane_t mem [Depth];
  logic [Depth-1:0] vld_q;
  fsbc_pkg::plane_t rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // unwritten entries read as the zero plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// File: hdl/fsbc_dist.sv
// ----------------------------------------------------------------------------
// fsbc_dist
// Three-stage plane distance pipe: products, partial sums, sign tests.
// ----------------------------------------------------------------------------
module fsbc_dist (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  vld_i,
  input  fsbc_pkg::plane_t                      plane_i,
  input  logic signed [fsbc_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [fsbc_pkg::POS_W-1:0]     pos_y_i,
  input  logic signed [fsbc_pkg::POS_W-1:0]     pos_z_i,
  input  logic [fsbc_pkg::RAD_W-1:0]            radius_i,
  output fsbc_pkg::dist_res_t                   res_o
);

  localparam int DW = fsbc_pkg::DIST_W;
  localparam int PadW = DW - fsbc_pkg::RAD_W - fsbc_pkg::FRAC_SHIFT;

  logic signed [fsbc_pkg::PROD_W-1:0] pa_q, pb_q, pc_q;
  logic signed [DW-1:0] pd_q;
  logic signed [DW-1:0] s1_q, s2_q, s2r_q;
  logic signed [DW-1:0] rad_s;
  logic signed [DW-1:0] dist_sum, dist_r;
  logic v1_q, v2_q, v3_q, cull_q, in_q;

  assign rad_s = $signed({{PadW{1'b0}}, radius_i, {fsbc_pkg::FRAC_SHIFT{1'b0}}});

  always_ff @(posedge clk_i) begin
    pa_q  <= plane_i.a * pos_x_i;
    pb_q  <= plane_i.b * pos_y_i;
    pc_q  <= plane_i.c * pos_z_i;
    pd_q  <= DW'(plane_i.d) <<< fsbc_pkg::FRAC_SHIFT;
    s1_q  <= DW'(pa_q) + DW'(pb_q);
    s2_q  <= DW'(pc_q) + pd_q;
    s2r_q <= DW'(pc_q) + pd_q + rad_s;
    in_q   <= ~dist_sum[DW-1];
    cull_q <= dist_r[DW-1];
  end

  assign dist_sum = s1_q + s2_q;
  assign dist_r   = s1_q + s2r_q;   // distance + radius < 0 means culled

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign res_o.vld      = v3_q;
  assign res_o.sph_cull = cull_q;
  assign res_o.box_in   = in_q;

endmodule

// File: hdl/frustum_sphere_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_sphere_box_cull
// Frustum culling of spheres and boxes against stored planes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata plane/coefs/pos/radius,
//                                           tuser op, tlast last_corner
//  m_axis    out  m_axis_tvalid/tready      tdata visible, tuser test_kind
//
// Flow: a plane load or an unused op is taken while idle. For a sphere or box
// corner the planes are read one per cycle from the plane memory and pass
// through one shared 3-stage multiply-add pipe; the finish state then posts
// the verdict (for a box, only at its last corner).
// Reset: planes read as zero, all corner flags set, output empty.
// Stalls: the output register holds one verdict; the next item is accepted
// while it waits and only stalls at its own verdict if it is still unread.
// ----------------------------------------------------------------------------
module frustum_sphere_box_cull #(
  parameter int NUM_PLANES = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // plane_index[2:0] a[18:3] b[34:19] c[50:35] d[82:51] x[114:83]
  // y[146:115] z[178:147] radius[209:179] zero pad[215:210]
  input  logic [fsbc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [fsbc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,   // op[1:0]
  input  logic                               s_axis_tlast,   // last_corner
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  output logic [fsbc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // visible[0], zero pad
  output logic                               m_axis_tuser,   // test_kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  localparam int IdxW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int CntW = $clog2(NUM_PLANES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_e;

  // --- input field unpack
  logic [2:0]                          in_idx;
  fsbc_pkg::plane_t                    in_plane;
  logic signed [fsbc_pkg::POS_W-1:0]   in_x, in_y, in_z;
  logic [fsbc_pkg::RAD_W-1:0]          in_rad;

  assign in_idx     = s_axis_tdata[2:0];
  assign in_plane.a = s_axis_tdata[18:3];
  assign in_plane.b = s_axis_tdata[34:19];
  assign in_plane.c = s_axis_tdata[50:35];
  assign in_plane.d = s_axis_tdata[82:51];
  assign in_x       = s_axis_tdata[114:83];
  assign in_y       = s_axis_tdata[146:115];
  assign in_z       = s_axis_tdata[178:147];
  assign in_rad     = s_axis_tdata[209:179];

  state_e                              state_q;
  logic [CntW-1:0]                     iss_cnt_q, ret_cnt_q;
  logic                                rd_vld_q;
  logic [NUM_PLANES-1:0]               flags_q;      // all corners outside, per plane
  logic                                cull_q;
  logic [1:0]                          op_q;
  logic                                last_q;
  logic signed [fsbc_pkg::POS_W-1:0]   x_q, y_q, z_q;
  logic [fsbc_pkg::RAD_W-1:0]          rad_q;
  logic                                out_vld_q, out_vis_q, out_kind_q;

  logic                                in_acc, mem_we, iss_done;
  logic                                post;         // verdict enters the output register
  fsbc_pkg::plane_t                    rd_plane;
  fsbc_pkg::dist_res_t                 res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  // loads only happen while idle and reads only while running: no overlap
  assign mem_we   = in_acc && (s_axis_tuser == fsbc_pkg::OP_LOAD)
                    && ({29'b0, in_idx} < 32'(NUM_PLANES));
  assign iss_done = (iss_cnt_q == CntW'(NUM_PLANES));
  assign post     = (state_q == ST_FINISH) && !(op_q == fsbc_pkg::OP_BOX && !last_q)
                    && (!out_vld_q || m_axis_tready);

  fsbc_plane_mem #(
    .Depth (NUM_PLANES),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (IdxW'(in_idx)),
    .wdata_i (in_plane),
    .raddr_i (iss_cnt_q[IdxW-1:0]),
    .rdata_o (rd_plane)
  );

  fsbc_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (rd_vld_q),
    .plane_i  (rd_plane),
    .pos_x_i  (x_q),
    .pos_y_i  (y_q),
    .pos_z_i  (z_q),
    .radius_i (rad_q),
    .res_o    (res)
  );

  // item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      last_q <= s_axis_tlast;
      x_q    <= in_x;
      y_q    <= in_y;
      z_q    <= in_z;
      rad_q  <= in_rad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_cnt_q  <= '0;
      ret_cnt_q  <= '0;
      rd_vld_q   <= 1'b0;
      flags_q    <= '1;
      cull_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_vis_q  <= 1'b0;
      out_kind_q <= fsbc_pkg::KIND_SPHERE;
    end else begin
      rd_vld_q <= (state_q == ST_RUN) && !iss_done;
      if (m_axis_tvalid && m_axis_tready && !post) out_vld_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == fsbc_pkg::OP_SPHERE ||
                         s_axis_tuser == fsbc_pkg::OP_BOX)) begin
            state_q   <= ST_RUN;
            iss_cnt_q <= '0;
            ret_cnt_q <= '0;
            cull_q    <= 1'b0;
          end
        end
        ST_RUN: begin
          if (!iss_done) iss_cnt_q <= iss_cnt_q + CntW'(1);
          if (res.vld) begin
            if (res.sph_cull) cull_q <= 1'b1;
            if (op_q == fsbc_pkg::OP_BOX && res.box_in) begin
              flags_q[ret_cnt_q[IdxW-1:0]] <= 1'b0;
            end
            if (ret_cnt_q == CntW'(NUM_PLANES - 1)) begin
              state_q <= ST_FINISH;
            end else begin
              ret_cnt_q <= ret_cnt_q + CntW'(1);
            end
          end
        end
        ST_FINISH: begin
          if (op_q == fsbc_pkg::OP_BOX && !last_q) begin
            state_q <= ST_IDLE;                 // inner corner: flags only
          end else if (post) begin
            out_vld_q <= 1'b1;
            if (op_q == fsbc_pkg::OP_BOX) begin
              out_vis_q  <= (flags_q == '0);
              out_kind_q <= fsbc_pkg::KIND_BOX;
              flags_q    <= '1;                 // arm for the next box
            end else begin
              out_vis_q  <= ~cull_q;
              out_kind_q <= fsbc_pkg::KIND_SPHERE;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(fsbc_pkg::OUT_TDATA_W-1){1'b0}}, out_vis_q};
  assign m_axis_tuser  = out_kind_q;

  // --- assertions
  a_res_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.vld |-> state_q == ST_RUN)
    else $error("distance result outside of a test");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_cnt_q <= CntW'(NUM_PLANES))
    else $error("plane issue counter overran");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FINISH))
    else $error("verdict posted outside of finish");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE && !rd_vld_q)
    else $error("plane write overlaps a plane read");

endmodule
